### rtl/core/bprl_pkg.sv
// Package for the bounded priority request list: sizes, field widths,
// operation and action codes, and the entry, row, request and result types.
// No dependencies.
`default_nettype none

package bprl_pkg;

  // Sizes
  localparam int unsigned PLAYERS    = 4;
  localparam int unsigned LIST_DEPTH = 5;

  // Fixed field widths
  localparam int unsigned OP_W   = 2;
  localparam int unsigned PL_W   = 2;
  localparam int unsigned ID_W   = 8;
  localparam int unsigned PRI_W  = 8;
  localparam int unsigned FADE_W = 8;

  // Derived widths
  localparam int unsigned CNT_W  = $clog2(LIST_DEPTH + 1);
  localparam int unsigned IDX_W  = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
  localparam int unsigned ADDR_W = (PLAYERS > 1) ? $clog2(PLAYERS) : 1;
  localparam int unsigned NUM_W  = 2;

  typedef enum logic [OP_W-1:0] {
    OP_QUEUE   = 2'd0,
    OP_UNQUEUE = 2'd1,
    OP_CLEAR   = 2'd2
  } op_e;

  typedef enum logic {
    ACT_START = 1'b0,
    ACT_STOP  = 1'b1
  } action_e;

  typedef struct packed {
    logic [ID_W-1:0]  id;
    logic [PRI_W-1:0] pri;
  } entry_t;

  typedef entry_t [LIST_DEPTH-1:0] row_t;

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [PL_W-1:0]   player;
    logic [ID_W-1:0]   id;
    logic [PRI_W-1:0]  pri;
    logic [FADE_W-1:0] fade;
  } req_t;

  typedef struct packed {
    action_e           action;
    logic [PL_W-1:0]   player;
    logic [ID_W-1:0]   id;
    logic [PRI_W-1:0]  pri;
    logic [FADE_W-1:0] fade;
    logic              last;
  } result_t;

  // What one update produces besides the new row and count
  typedef struct packed {
    logic             row_we;
    logic             cnt_we;
    logic [NUM_W-1:0] num;
    result_t          first;
    result_t          second;
  } upd_ctl_t;

endpackage

`default_nettype wire

### rtl/core/bprl_req_if.sv
// Request channel: valid/ready handshake with the request fields.
// Depends on bprl_pkg.
`default_nettype none

interface bprl_req_if;
  import bprl_pkg::*;

  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   operation;
  logic [PL_W-1:0]   player;
  logic [ID_W-1:0]   request_id;
  logic [PRI_W-1:0]  priority_req;
  logic [FADE_W-1:0] fade_time;

  modport source (
    output valid, operation, player, request_id, priority_req, fade_time,
    input  ready
  );

  modport sink (
    input  valid, operation, player, request_id, priority_req, fade_time,
    output ready
  );

endinterface

`default_nettype wire

### rtl/core/bprl_res_if.sv
// Result channel: valid/ready handshake with the action fields.
// Depends on bprl_pkg.
`default_nettype none

interface bprl_res_if;
  import bprl_pkg::*;

  logic              valid;
  logic              ready;
  logic              action;
  logic [PL_W-1:0]   out_player;
  logic [ID_W-1:0]   out_id;
  logic [PRI_W-1:0]  out_priority;
  logic [FADE_W-1:0] out_fade;
  logic              last;

  modport source (
    output valid, action, out_player, out_id, out_priority, out_fade, last,
    input  ready
  );

  modport sink (
    input  valid, action, out_player, out_id, out_priority, out_fade, last,
    output ready
  );

endinterface

`default_nettype wire

### rtl/core/bprl_list_upd.sv
// Modify step of the read-modify-write: takes one player's row and count,
// applies a request and gives the new row, new count and up to two results.
// Depends on bprl_pkg.
`default_nettype none

module bprl_list_upd (
  input  bprl_pkg::row_t                  row_i,
  input  logic [bprl_pkg::CNT_W-1:0]      cnt_i,
  input  bprl_pkg::req_t                  req_i,
  output bprl_pkg::row_t                  row_o,
  output logic [bprl_pkg::CNT_W-1:0]      cnt_o,
  output bprl_pkg::upd_ctl_t              ctl_o
);
  import bprl_pkg::*;

  logic [LIST_DEPTH-1:0] hit_id;
  logic [LIST_DEPTH-1:0] pri_le;
  logic                  hit_any;
  logic                  ins_any;
  logic [IDX_W-1:0]      hit_idx;
  logic [IDX_W-1:0]      ins_idx;
  logic [CNT_W-1:0]      pos;
  logic                  pl_ok;
  entry_t                new_ent;
  result_t               res_start_req;
  result_t               res_stop;

  // Per-entry compares against the valid part of the row
  always_comb begin
    for (int i = 0; i < LIST_DEPTH; i++) begin
      hit_id[i] = (CNT_W'(i) < cnt_i) && (row_i[i].id == req_i.id);
      pri_le[i] = (CNT_W'(i) < cnt_i) && (row_i[i].pri <= req_i.pri);
    end
  end

  // First matching entry and first insertion slot
  always_comb begin
    hit_idx = '0;
    ins_idx = '0;
    for (int i = LIST_DEPTH - 1; i >= 0; i--) begin
      if (hit_id[i]) begin
        hit_idx = IDX_W'(i);
      end
      if (pri_le[i]) begin
        ins_idx = IDX_W'(i);
      end
    end
  end

  assign hit_any = |hit_id;
  assign ins_any = |pri_le;
  assign pos     = ins_any ? CNT_W'(ins_idx) : cnt_i;
  assign pl_ok   = (32'(req_i.player) < 32'(PLAYERS));
  assign new_ent = '{id: req_i.id, pri: req_i.pri};

  assign res_start_req = '{action: ACT_START, player: req_i.player, id: req_i.id,
                           pri: req_i.pri, fade: req_i.fade, last: 1'b0};
  assign res_stop      = '{action: ACT_STOP, player: req_i.player, id: '0,
                           pri: '0, fade: req_i.fade, last: 1'b0};

  // Apply the operation
  always_comb begin
    row_o        = row_i;
    cnt_o        = cnt_i;
    ctl_o        = '0;
    ctl_o.first  = res_start_req;
    ctl_o.second = res_start_req;

    if (pl_ok) begin
      case (req_i.op)
        OP_QUEUE: begin
          if (hit_any) begin
            // Repeat of a listed ID: restart only when it is the head
            if (hit_idx == '0) begin
              ctl_o.num = NUM_W'(1);
            end
          end else if (pos < CNT_W'(LIST_DEPTH)) begin
            for (int i = 0; i < LIST_DEPTH; i++) begin
              if (CNT_W'(i) == pos) begin
                row_o[i] = new_ent;
              end else if (i > 0 && CNT_W'(i) > pos) begin
                row_o[i] = row_i[(i > 0) ? i - 1 : 0];
              end
            end
            cnt_o        = (cnt_i < CNT_W'(LIST_DEPTH)) ? cnt_i + CNT_W'(1) : cnt_i;
            ctl_o.row_we = 1'b1;
            ctl_o.cnt_we = 1'b1;
            if (pos == '0) begin
              ctl_o.num = NUM_W'(1);
            end
          end
        end
        OP_UNQUEUE: begin
          if (hit_any) begin
            for (int i = 0; i < LIST_DEPTH - 1; i++) begin
              if (IDX_W'(i) >= hit_idx) begin
                row_o[i] = row_i[i + 1];
              end
            end
            cnt_o        = cnt_i - CNT_W'(1);
            ctl_o.row_we = 1'b1;
            ctl_o.cnt_we = 1'b1;
          end
          // Head removed, or list already empty: stop, then start the new head if one is left
          if ((hit_any && hit_idx == '0) || cnt_i == '0) begin
            ctl_o.first = res_stop;
            if (hit_any && cnt_i > CNT_W'(1)) begin
              ctl_o.num    = NUM_W'(2);
              ctl_o.second = '{action: ACT_START, player: req_i.player,
                               id: row_i[1].id, pri: row_i[1].pri,
                               fade: req_i.fade, last: 1'b0};
            end else begin
              ctl_o.num = NUM_W'(1);
            end
          end
        end
        OP_CLEAR: begin
          cnt_o        = '0;
          ctl_o.cnt_we = 1'b1;
        end
        default: begin
        end
      endcase
    end

    // Mark the final result of this request
    if (ctl_o.num == NUM_W'(1)) begin
      ctl_o.first.last = 1'b1;
    end
    if (ctl_o.num == NUM_W'(2)) begin
      ctl_o.second.last = 1'b1;
    end
  end

endmodule

`default_nettype wire

### rtl/core/bounded_priority_request_list_core.sv
// Top level of the bounded priority request list: row memory, per-player
// counts, control sequencer and result register.
// Depends on bprl_pkg, bprl_req_if, bprl_res_if and bprl_list_upd.
//
//   channel | dir | beat contents
//   --------+-----+-----------------------------------------------------------
//   req_i   | in  | operation, player, request_id, priority_req, fade_time
//   res_o   | out | action, out_player, out_id, out_priority, out_fade, last
//
// A request is handled in steps: the row is read from memory on accept, then
// modified and written back, then each result beat it causes (none, one or
// two) is sent on res_o. One request is handled at a time; req_i.ready is
// high only when idle. Reset clears the counts and the sequencer state; the
// row memory is not cleared and needs no clearing pass.
// A stall on res_o holds the current result beat and the request side.
`default_nettype none

module bounded_priority_request_list_core (
  input  logic clk_i,
  input  logic rst_ni,
  bprl_req_if.sink   req_i,
  bprl_res_if.source res_o
);
  import bprl_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CALC,
    ST_OUT
  } state_e;

  state_e            state_q;
  req_t              req_q;
  logic [ADDR_W-1:0] addr_q;
  row_t              row_mem [PLAYERS];
  row_t              rdata_q;
  logic [CNT_W-1:0]  cnt_q [PLAYERS];
  logic [CNT_W-1:0]  cnt_rd;
  result_t           out_q;
  result_t           pend_q;
  logic              out_v_q;
  logic              pend_v_q;
  logic              req_acc;
  logic [ADDR_W-1:0] addr_in;
  row_t              row_d;
  logic [CNT_W-1:0]  cnt_d;
  upd_ctl_t          ctl;

  assign req_i.ready = (state_q == ST_IDLE);
  assign req_acc     = req_i.valid && req_i.ready;
  assign addr_in     = ADDR_W'(req_i.player);
  assign cnt_rd      = cnt_q[addr_q];

  // Row memory: read on accept, write back in the modify cycle
  always_ff @(posedge clk_i) begin
    if (req_acc) begin
      rdata_q <= row_mem[addr_in];
    end
    if (state_q == ST_CALC && ctl.row_we) begin
      row_mem[addr_q] <= row_d;
    end
  end

  // Modify step
  bprl_list_upd u_upd (
    .row_i (rdata_q),
    .cnt_i (cnt_rd),
    .req_i (req_q),
    .row_o (row_d),
    .cnt_o (cnt_d),
    .ctl_o (ctl)
  );

  // Per-player entry counts
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int p = 0; p < PLAYERS; p++) begin
        cnt_q[p] <= '0;
      end
    end else if (state_q == ST_CALC && ctl.cnt_we) begin
      cnt_q[addr_q] <= cnt_d;
    end
  end

  // Request latch
  always_ff @(posedge clk_i) begin
    if (req_acc) begin
      req_q  <= '{op: req_i.operation, player: req_i.player, id: req_i.request_id,
                  pri: req_i.priority_req, fade: req_i.fade_time};
      addr_q <= addr_in;
    end
  end

  // Sequencer and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      out_v_q  <= 1'b0;
      pend_v_q <= 1'b0;
      out_q    <= '0;
      pend_q   <= '0;
    end else begin
      case (state_q)
        ST_IDLE: begin
          if (req_acc) begin
            state_q <= ST_CALC;
          end
        end
        ST_CALC: begin
          if (ctl.num == '0) begin
            state_q <= ST_IDLE;
          end else begin
            out_q    <= ctl.first;
            pend_q   <= ctl.second;
            out_v_q  <= 1'b1;
            pend_v_q <= (ctl.num == NUM_W'(2));
            state_q  <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (res_o.ready) begin
            if (pend_v_q) begin
              out_q    <= pend_q;
              pend_v_q <= 1'b0;
            end else begin
              out_v_q <= 1'b0;
              state_q <= ST_IDLE;
            end
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign res_o.valid        = out_v_q;
  assign res_o.action       = out_q.action;
  assign res_o.out_player   = out_q.player;
  assign res_o.out_id       = out_q.id;
  assign res_o.out_priority = out_q.pri;
  assign res_o.out_fade     = out_q.fade;
  assign res_o.last         = out_q.last;

`ifndef SYNTH
  // No new request while a result beat is still waiting
  a_no_accept_with_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_acc |-> !res_o.valid)
    else $error("request accepted while a result beat is pending");

  // A queued second result only exists behind a valid first one
  a_pend_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_v_q |-> (res_o.valid && !res_o.last))
    else $error("second result pending without a non-final first beat");

  // The count written back never exceeds the list depth
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CALC && ctl.cnt_we) |-> (cnt_d <= CNT_W'(LIST_DEPTH)))
    else $error("entry count beyond list depth");

  // A stalled result beat is held and keeps the block busy
  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.valid && !res_o.ready) |=> (res_o.valid && !req_i.ready))
    else $error("stalled result beat dropped or request side reopened");
`endif

endmodule

`default_nettype wire
